FILE: design/dddf_pkg.sv
// ----------------------------------------------------------------------------
// Decimal digit display framer package
// Word types, sizing constants and codes that the framer modules share.
// ----------------------------------------------------------------------------
`default_nettype none

package dddf_pkg;

  // Number of digit positions on the display.
  localparam int unsigned DIGIT_COUNT = 8;

  // Field widths.
  localparam int unsigned NUMBER_W = 32;
  localparam int unsigned SHOWN_W  = 4;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned CODE_W   = 4;
  localparam int unsigned FRAME_W  = 16;
  localparam int unsigned BYTE_W   = 8;

  // Codes.
  localparam logic [CODE_W-1:0] BLANK_CODE = 4'd15;
  localparam logic [POS_W-1:0]  FIRST_POS  = 4'd1;
  localparam logic [POS_W-1:0]  LAST_POS   = POS_W'(DIGIT_COUNT);
  localparam logic [SHOWN_W-1:0] MAX_SHOWN = SHOWN_W'(DIGIT_COUNT);

  // Divide by ten: reciprocal ceil(2^35 / 10) is exact for every 32-bit value.
  localparam int unsigned        RECIP_SHIFT = 35;
  localparam logic [NUMBER_W-1:0] RECIP_TEN  = 32'hCCCC_CCCD;
  localparam int unsigned        PROD_W      = 2 * NUMBER_W;

  // Queue between front and back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Input word.
  typedef struct packed {
    logic [NUMBER_W-1:0] number;
    logic [SHOWN_W-1:0]  shown_digits;
  } req_t;

  // Result word.
  typedef struct packed {
    logic [POS_W-1:0]   digit_position;
    logic [CODE_W-1:0]  digit_code;
    logic [FRAME_W-1:0] frame_word;
    logic               last_frame;
    logic               overflow;
  } res_t;

  // Head of the queue as seen by the back part.
  typedef struct packed {
    logic valid;
    req_t item;
  } head_t;

endpackage

`default_nettype wire

FILE: design/dddf_front.sv
// ----------------------------------------------------------------------------
// Framer front
// Accepts request words, clamps the digit count and queues them for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dddf_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire dddf_pkg::req_t req_i,
  output dddf_pkg::head_t     head_o,
  input  wire logic           pop_i
);

  dddf_pkg::req_t                    mem_q [dddf_pkg::QDEPTH];
  logic [dddf_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [dddf_pkg::QCNT_W-1:0]       cnt_q, cnt_d;
  logic                              push;
  dddf_pkg::req_t                    clamped;

  // A word is taken whenever the queue has room.
  assign busy = (cnt_q == dddf_pkg::QCNT_W'(dddf_pkg::QDEPTH));
  assign push = start && !busy;

  // Digit counts above the display size show every position.
  always_comb begin
    clamped = req_i;
    if (req_i.shown_digits > dddf_pkg::MAX_SHOWN) begin
      clamped.shown_digits = dddf_pkg::MAX_SHOWN;
    end
  end

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == dddf_pkg::QPTR_W'(dddf_pkg::QDEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == dddf_pkg::QPTR_W'(dddf_pkg::QDEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= clamped;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  // The back never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> head_o.valid)
    else $error("pop from empty queue");

  // The fill count stays within the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cnt_q <= dddf_pkg::QCNT_W'(dddf_pkg::QDEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

FILE: design/dddf_back.sv
// ----------------------------------------------------------------------------
// Framer back
// Peels one decimal digit per cycle and drives one display frame per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dddf_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire dddf_pkg::head_t head_i,
  output logic                 pop_o,
  output dddf_pkg::res_t       res_o,
  output logic                 res_valid_o
);

  logic                               active_q, active_d;
  logic [dddf_pkg::NUMBER_W-1:0]      rest_q, rest_d;
  logic [dddf_pkg::SHOWN_W-1:0]       shown_q, shown_d;
  logic [dddf_pkg::POS_W-1:0]         pos_q, pos_d;
  logic                               at_last;
  logic [dddf_pkg::PROD_W-1:0]        prod;
  logic [dddf_pkg::NUMBER_W-1:0]      quot;
  logic [dddf_pkg::NUMBER_W-1:0]      rem_full;
  logic [dddf_pkg::CODE_W-1:0]        code;
  dddf_pkg::res_t                     res_q, res_d;
  logic                               valid_q;

  assign at_last = (pos_q == dddf_pkg::LAST_POS);

  // Next item loads as the current one emits its final frame.
  assign pop_o = head_i.valid && (!active_q || at_last);

  // Divide the remaining value by ten through the reciprocal.
  assign prod = dddf_pkg::PROD_W'(rest_q) * dddf_pkg::PROD_W'(dddf_pkg::RECIP_TEN);
  assign quot = dddf_pkg::NUMBER_W'(prod >> dddf_pkg::RECIP_SHIFT);
  assign rem_full = rest_q - ((quot << 3) + (quot << 1));
  assign code = (pos_q <= shown_q) ? rem_full[dddf_pkg::CODE_W-1:0] : dddf_pkg::BLANK_CODE;

  // Frame for the current position.
  always_comb begin
    res_d.digit_position = pos_q;
    res_d.digit_code     = code;
    res_d.frame_word     = {{(dddf_pkg::BYTE_W - dddf_pkg::POS_W){1'b0}}, pos_q,
                            {(dddf_pkg::BYTE_W - dddf_pkg::CODE_W){1'b0}}, code};
    res_d.last_frame     = at_last;
    res_d.overflow       = at_last && (quot != '0);
  end

  // Digit sequencer.
  always_comb begin
    active_d = active_q;
    rest_d   = rest_q;
    shown_d  = shown_q;
    pos_d    = pos_q;
    if (pop_o) begin
      active_d = 1'b1;
      rest_d   = head_i.item.number;
      shown_d  = head_i.item.shown_digits;
      pos_d    = dddf_pkg::FIRST_POS;
    end else if (active_q) begin
      active_d = !at_last;
      rest_d   = quot;
      pos_d    = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      valid_q  <= 1'b0;
      pos_q    <= dddf_pkg::FIRST_POS;
    end else begin
      active_q <= active_d;
      valid_q  <= active_q;
      pos_q    <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q  <= rest_d;
    shown_q <= shown_d;
    res_q   <= res_d;
  end

  assign res_o       = res_q;
  assign res_valid_o = valid_q;

  // Frames of one run come in consecutive cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   valid_q && !res_q.last_frame |=> valid_q)
    else $error("gap inside a frame run");

  // The run closes on the top position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   valid_q && res_q.last_frame |-> res_q.digit_position == dddf_pkg::LAST_POS)
    else $error("last frame on wrong position");

  // Overflow is flagged on the final frame only.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   valid_q && res_q.overflow |-> res_q.last_frame)
    else $error("overflow off the last frame");

endmodule

`default_nettype wire

FILE: design/decimal_digit_display_framer_unit.sv
// ----------------------------------------------------------------------------
// Decimal digit display framer
// Turns a number and a digit count into eight display frames, one per cycle.
// ----------------------------------------------------------------------------
// Throughput: one frame per cycle, set by the one-digit-per-cycle divide-by-ten
// step in the back; a two-word queue absorbs new starts.
// Reset clears the queue and the sequencer; no frames follow reset until a
// start. The receiver takes every frame in the cycle it is shown.
`default_nettype none

module decimal_digit_display_framer_unit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire dddf_pkg::req_t req_i,
  output dddf_pkg::res_t      res_o,
  output logic                res_valid_o
);

  dddf_pkg::head_t head;
  logic            pop;

  // Request intake and queue.
  dddf_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .head_o (head),
    .pop_i  (pop)
  );

  // Digit extraction and frame output.
  dddf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb_decimal_digit_display_framer_unit.sv
// ----------------------------------------------------------------------------
// Decimal digit display framer testbench
// Sends number and digit count words to the framer, predicts the eight
// display frames of each word and checks every frame that the block shows.
// A corner sweep comes first, then random words under three sender
// idling profiles.
// ----------------------------------------------------------------------------
module tb_decimal_digit_display_framer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import dddf_pkg::*;

  localparam int unsigned RADIX        = 10;
  localparam int unsigned WORDS_PER_PH = 116;
  localparam int unsigned DRAIN_CYCLES = 16;

  // Predicted frames and the checks against them.
  class frame_scoreboard;
    res_t        pending_frames[$];
    int unsigned fails;

    function new();
      fails = 0;
    endfunction

    // Works out the eight frames that an accepted word will produce.
    function void note_request(req_t w);
      logic [NUMBER_W-1:0] rest;
      logic [SHOWN_W-1:0]  shown;
      res_t                f;
      rest  = w.number;
      shown = (w.shown_digits > MAX_SHOWN) ? MAX_SHOWN : w.shown_digits;
      for (int unsigned pos = 1; pos <= DIGIT_COUNT; pos++) begin
        f.digit_position = POS_W'(pos);
        f.digit_code     = (pos <= shown) ? CODE_W'(rest % RADIX) : BLANK_CODE;
        rest             = rest / RADIX;
        f.frame_word     = {BYTE_W'(f.digit_position), BYTE_W'(f.digit_code)};
        f.last_frame     = (pos == DIGIT_COUNT);
        f.overflow       = f.last_frame && (rest != 0);
        pending_frames.push_back(f);
      end
    endfunction

    // Compares one shown frame with the oldest prediction.
    function void check_frame(res_t got);
      res_t exp_f;
      if (pending_frames.size() == 0) begin
        $error("frame shown with no prediction waiting: %h", got);
        fails++;
        return;
      end
      exp_f = pending_frames.pop_front();
      if (got.digit_position !== exp_f.digit_position) begin
        $error("digit_position expected %0d actual %0d",
               exp_f.digit_position, got.digit_position);
        fails++;
      end
      if (got.digit_code !== exp_f.digit_code) begin
        $error("digit_code expected %0d actual %0d", exp_f.digit_code, got.digit_code);
        fails++;
      end
      if (got.frame_word !== exp_f.frame_word) begin
        $error("frame_word expected %h actual %h", exp_f.frame_word, got.frame_word);
        fails++;
      end
      if (got.last_frame !== exp_f.last_frame) begin
        $error("last_frame expected %0d actual %0d", exp_f.last_frame, got.last_frame);
        fails++;
      end
      if (got.overflow !== exp_f.overflow) begin
        $error("overflow expected %0d actual %0d", exp_f.overflow, got.overflow);
        fails++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  res_t res_o;
  logic res_valid_o;

  frame_scoreboard frames_sb = new();

  decimal_digit_display_framer_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_o      (res_o),
    .res_valid_o(res_valid_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #1ms;
    $display("Regression FAIL");
    $finish;
  end

  // Every frame is taken in the cycle it is shown.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      frames_sb.check_frame(res_o);
    end
  end

  // Offers one word after a random idle gap and holds it until accepted.
  task automatic send_word(req_t w, int unsigned idle_pct);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= w;
    do @(posedge clk_i); while (busy);
    frames_sb.note_request(w);
  endtask

  // Stimulus and end of run.
  initial begin
    req_t        corner_words[$];
    req_t        w;
    int unsigned idle_pct[3];
    rst_ni <= 1'b0;
    start  <= 1'b0;
    req_i  <= '0;
    idle_pct = '{9, 46, 0};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Corner sweep: every digit count, clamped counts, zero digits shown,
    // leading zeros and both sides of the overflow boundary.
    for (int unsigned s = 0; s <= 8; s++) begin
      corner_words.push_back('{number: 32'd87654321, shown_digits: SHOWN_W'(s)});
    end
    corner_words.push_back('{number: 32'd12345678, shown_digits: 4'd9});
    corner_words.push_back('{number: 32'd12345678, shown_digits: 4'd15});
    corner_words.push_back('{number: 32'd0,        shown_digits: 4'd8});
    corner_words.push_back('{number: 32'd0,        shown_digits: 4'd0});
    corner_words.push_back('{number: 32'hFFFF_FFFF, shown_digits: 4'd8});
    corner_words.push_back('{number: 32'hFFFF_FFFF, shown_digits: 4'd0});
    corner_words.push_back('{number: 32'hFFFF_FFFF, shown_digits: 4'd15});
    corner_words.push_back('{number: 32'd99999999, shown_digits: 4'd8});
    corner_words.push_back('{number: 32'd100000000, shown_digits: 4'd8});
    corner_words.push_back('{number: 32'd100000000, shown_digits: 4'd3});
    corner_words.push_back('{number: 32'd10,       shown_digits: 4'd8});
    corner_words.push_back('{number: 32'd7,        shown_digits: 4'd1});
    corner_words.push_back('{number: 32'd90909090, shown_digits: 4'd12});
    foreach (corner_words[i]) send_word(corner_words[i], 0);

    // Random words under each idling profile.
    for (int ph = 0; ph < 3; ph++) begin
      for (int unsigned n = 0; n < WORDS_PER_PH; n++) begin
        case ($urandom_range(4))
          0:       w.number = $urandom_range(9);
          1:       w.number = $urandom_range(99999999);
          2:       w.number = 32'd99999990 + $urandom_range(20);
          default: w.number = $urandom();
        endcase
        w.shown_digits = ($urandom_range(3) == 0) ? SHOWN_W'($urandom_range(15))
                                                  : SHOWN_W'($urandom_range(8));
        send_word(w, idle_pct[ph]);
      end
    end
    start <= 1'b0;

    // Let the last frames drain, then a few quiet cycles.
    while (frames_sb.pending_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (frames_sb.pending_frames.size() != 0) begin
      $error("%0d predicted frames never shown", frames_sb.pending_frames.size());
      frames_sb.fails++;
    end

    if (frames_sb.fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/dddf_pkg.sv
design/dddf_front.sv
design/dddf_back.sv
design/decimal_digit_display_framer_unit.sv
tb/sv/tb_decimal_digit_display_framer_unit.sv
